@@ hdl/grc_pkg.sv @@
package grc_pkg;

  // fixed field widths
  localparam int CELL_W = 6;
  localparam int POS_W  = 22;
  localparam int DIR_W  = 18;
  localparam int DIST_W = 24;
  localparam int SD_W   = 32;
  localparam int H_W    = 12;
  localparam int HS_W   = 16;
  localparam int TW_W   = 11;
  localparam int TEX_W  = 10;
  localparam int LH_W   = 21;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [SD_W-1:0]   SD_CAP   = '1;
  localparam logic [DIST_W-1:0] DIST_CAP = '1;
  localparam logic [LH_W-1:0]   LH_CAP   = LH_W'(1) << (LH_W - 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_SCALE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH     = 2'd2;

  localparam logic [H_W-1:0]  SCREEN_HEIGHT_RST = 12'd480;
  localparam logic [HS_W-1:0] HEIGHT_SCALE_RST  = 16'd640;
  localparam logic [TW_W-1:0] TEX_WIDTH_RST     = 11'd64;

  // face codes
  localparam logic [1:0] FACE_EAST  = 2'd0;
  localparam logic [1:0] FACE_WEST  = 2'd1;
  localparam logic [1:0] FACE_SOUTH = 2'd2;
  localparam logic [1:0] FACE_NORTH = 2'd3;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_RAY   = 1'b1;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DELX,
    ST_DELY,
    ST_DIV,
    ST_DIVEND,
    ST_SIDEX,
    ST_SIDEY,
    ST_SIDEND,
    ST_STEP,
    ST_CHECK,
    ST_PERP,
    ST_LH,
    ST_TEX0,
    ST_TEX1,
    ST_TEX2,
    ST_TEX3,
    ST_TEX4,
    ST_DONE
  } st_t;

  typedef enum logic [1:0] {
    DOP_DX,
    DOP_DY,
    DOP_PERP,
    DOP_LH
  } dop_t;

endpackage

@@ hdl/grid_ray_caster.sv @@
// Channel   Dir  Handshake              Payload
// in        in   in_valid / in_stall    func, cell_x, cell_y, cell_wall, player_*, dir_*
// out       out  out_valid / out_stall  wall_distance .. tex_column, is_ray
// cfg       in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A map write is stored when it is accepted and acknowledged from ST_DONE. For a ray,
// one shared restoring divider (one quotient bit a cycle, NUMW = 39 at the default
// parameters) computes both deltas, the wall distance and the line height, and each
// grid step (ST_STEP, then ST_CHECK) waits for the registered map read. While busy, in_stall is high.
// After reset the map is cleared, one cell a cycle, all MAP_DIM*MAP_DIM (4096) cells.
// A finished result waits in the output register while the next item is accepted.
module grid_ray_caster #(
  parameter int MAP_DIM   = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                func,
  input  logic [grc_pkg::CELL_W-1:0]          cell_x,
  input  logic [grc_pkg::CELL_W-1:0]          cell_y,
  input  logic                                cell_wall,
  input  logic [grc_pkg::POS_W-1:0]           player_x,
  input  logic [grc_pkg::POS_W-1:0]           player_y,
  input  logic signed [grc_pkg::DIR_W-1:0]    dir_x,
  input  logic signed [grc_pkg::DIR_W-1:0]    dir_y,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [grc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [grc_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [grc_pkg::DIST_W-1:0]          wall_distance,
  output logic                                hit_side,
  output logic [1:0]                          face,
  output logic [grc_pkg::CELL_W-1:0]          hit_x,
  output logic [grc_pkg::CELL_W-1:0]          hit_y,
  output logic                                left_map,
  output logic [grc_pkg::H_W-1:0]             draw_start,
  output logic [grc_pkg::H_W-1:0]             draw_end,
  output logic [grc_pkg::TEX_W-1:0]           tex_column,
  output logic                                is_ray
);

  localparam int EW      = $clog2(MAP_DIM + 1);
  localparam int CSW     = EW + 1;
  localparam int DEPTH   = MAP_DIM * MAP_DIM;
  localparam int AW      = $clog2(DEPTH);
  localparam int NB1     = (EW + FRAC_BITS > grc_pkg::POS_W) ? EW + FRAC_BITS : grc_pkg::POS_W;
  localparam int PERP_W  = NB1 + FRAC_BITS;
  localparam int DELTA_W = 2 * FRAC_BITS + 1;
  localparam int LH_NW   = grc_pkg::HS_W + FRAC_BITS;
  localparam int NUMW0   = (PERP_W > DELTA_W) ? PERP_W : DELTA_W;
  localparam int NUMW    = (NUMW0 > LH_NW) ? NUMW0 : LH_NW;
  localparam int DW      = grc_pkg::DIST_W;
  localparam int CNT_W   = $clog2(NUMW);
  localparam int FRAC1   = FRAC_BITS + 1;
  localparam int MA      = (FRAC1 > grc_pkg::DIST_W) ? FRAC1 : grc_pkg::DIST_W;
  localparam int MB      = grc_pkg::SD_W;
  localparam int MP      = MA + MB;
  localparam int ACC_W   = 2 * FRAC_BITS;

  localparam logic [63:0]           PLIM    = 64'(MAP_DIM) << FRAC_BITS;
  localparam logic [63:0]           FMASK   = (64'(1) << FRAC_BITS) - 64'(1);
  localparam logic signed [CSW-1:0] MAP_S   = CSW'(MAP_DIM);
  localparam logic signed [CSW-1:0] MAP_MAX = CSW'(MAP_DIM - 1);
  localparam logic [AW-1:0]         MAP_A   = AW'(MAP_DIM);
  localparam logic [AW-1:0]         LAST_A  = AW'(DEPTH - 1);

  grc_pkg::st_t  state, state_next;
  grc_pkg::dop_t div_op;

  logic [grc_pkg::H_W-1:0]  screen_height;
  logic [grc_pkg::HS_W-1:0] height_scale;
  logic [grc_pkg::TW_W-1:0] tex_width;

  logic [AW-1:0] clr_addr;

  // working registers
  logic [grc_pkg::POS_W-1:0]        px, py;
  logic signed [grc_pkg::DIR_W-1:0] dx, dy;
  logic signed [CSW-1:0]            cx, cy;
  logic [grc_pkg::SD_W-1:0]         delta_x, delta_y, side_x, side_y;
  logic [grc_pkg::DIST_W-1:0]       wdist;
  logic                             side, left, is_ray_w;
  logic [grc_pkg::LH_W-1:0]         lh;
  logic [ACC_W-1:0]                 acc;
  logic [grc_pkg::TW_W-1:0]         tex_lo, tex;
  logic [MP-1:0]                    prod;

  logic [NUMW-1:0]  div_num, div_q;
  logic [DW-1:0]    div_rem, div_den;
  logic [CNT_W-1:0] div_cnt;

  logic wmap [DEPTH];
  logic mem_q;
  logic mem_we, mem_wdata;
  logic [AW-1:0] mem_waddr, rd_addr;

  logic in_acc, out_free;

  // input-side decode
  logic [63:0]           cx0_w, cy0_w;
  logic                  out_x, out_y, cell_ok;
  logic [AW-1:0]         wr_addr;

  // direction magnitudes
  logic [grc_pkg::DIR_W-1:0] dmx, dmy, dmag_o;
  logic [FRAC1-1:0]          frac_x, frac_y, flx, fly;

  // walk step
  logic                  take_x, in_map_n;
  logic signed [CSW-1:0] step_x, step_y, cx_n, cy_n;
  logic [grc_pkg::SD_W:0] sum_x, sum_y;

  // perpendicular distance numerator
  logic signed [CSW-1:0]     p_cell;
  logic                      p_neg;
  logic [grc_pkg::POS_W-1:0] p_pos;
  logic [grc_pkg::DIR_W-1:0] p_dmag;
  logic [EW-1:0]             p_edge;
  logic signed [NB1:0]       p_diff;
  logic [NB1-1:0]            p_mag;

  // shared multiplier
  logic [MA-1:0] mul_a;
  logic [MB-1:0] mul_b;
  logic [MP-1:0] mul_p;
  logic [MP-1:0] prod_sh;

  // shared divider
  logic [DW:0]   div_trial;
  logic          div_ge;
  logic [DW-1:0] div_rem_n;

  // texture accumulate
  logic [ACC_W-1:0] tp_sh, pr_lo, acc_n;

  // result shaping
  logic [grc_pkg::LH_W-2:0]  half;
  logic [grc_pkg::LH_W-1:0]  hh, start_w, end_w;
  logic                      mirror;
  logic [grc_pkg::TW_W-1:0]  tex_f;
  logic [CSW-1:0]            hx_c, hy_c;
  logic [1:0]                face_w;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    cx0_w   = 64'(player_x) >> FRAC_BITS;
    cy0_w   = 64'(player_y) >> FRAC_BITS;
    out_x   = 64'(player_x) >= PLIM;
    out_y   = 64'(player_y) >= PLIM;
    cell_ok = (32'(cell_x) < 32'(MAP_DIM)) && (32'(cell_y) < 32'(MAP_DIM));
    wr_addr = AW'(AW'(cell_y) * MAP_A + AW'(cell_x));
  end

  always_comb begin
    dmx    = dx[grc_pkg::DIR_W-1] ? grc_pkg::DIR_W'(-dx) : grc_pkg::DIR_W'(dx);
    dmy    = dy[grc_pkg::DIR_W-1] ? grc_pkg::DIR_W'(-dy) : grc_pkg::DIR_W'(dy);
    dmag_o = side ? dmx : dmy;
    flx    = FRAC1'(64'(px) & FMASK);
    fly    = FRAC1'(64'(py) & FMASK);
    frac_x = dx[grc_pkg::DIR_W-1] ? flx : (FRAC1'(1) << FRAC_BITS) - flx;
    frac_y = dy[grc_pkg::DIR_W-1] ? fly : (FRAC1'(1) << FRAC_BITS) - fly;
  end

  // one grid step: smaller side distance wins, ties go to y
  always_comb begin
    take_x   = side_x < side_y;
    step_x   = dx[grc_pkg::DIR_W-1] ? CSW'(-1) : CSW'(1);
    step_y   = dy[grc_pkg::DIR_W-1] ? CSW'(-1) : CSW'(1);
    cx_n     = take_x ? cx + step_x : cx;
    cy_n     = take_x ? cy : cy + step_y;
    sum_x    = {1'b0, side_x} + {1'b0, delta_x};
    sum_y    = {1'b0, side_y} + {1'b0, delta_y};
    in_map_n = !cx_n[CSW-1] && (cx_n < MAP_S) && !cy_n[CSW-1] && (cy_n < MAP_S);
    rd_addr  = in_map_n ? AW'(AW'(cy_n) * MAP_A + AW'(cx_n)) : '0;
  end

  always_comb begin
    p_cell = side ? cy : cx;
    p_neg  = side ? dy[grc_pkg::DIR_W-1] : dx[grc_pkg::DIR_W-1];
    p_pos  = side ? py : px;
    p_dmag = side ? dmy : dmx;
    p_edge = EW'(p_cell + (p_neg ? CSW'(1) : CSW'(0)));
    p_diff = ((NB1 + 1)'(p_edge) << FRAC_BITS) - (NB1 + 1)'(p_pos);
    p_mag  = p_diff[NB1] ? NB1'(-p_diff) : NB1'(p_diff);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      grc_pkg::ST_SIDEX: begin
        mul_a = MA'(frac_x);
        mul_b = delta_x;
      end
      grc_pkg::ST_SIDEY: begin
        mul_a = MA'(frac_y);
        mul_b = delta_y;
      end
      grc_pkg::ST_TEX0: begin
        mul_a = MA'(wdist);
        mul_b = MB'(dmag_o);
      end
      grc_pkg::ST_TEX2: begin
        mul_a = MA'(acc[FRAC_BITS-1:0]);
        mul_b = MB'(tex_width);
      end
      grc_pkg::ST_TEX3: begin
        mul_a = MA'(acc[ACC_W-1:FRAC_BITS]);
        mul_b = MB'(tex_width);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p   = MP'(mul_a) * MP'(mul_b);
    prod_sh = prod >> FRAC_BITS;
  end

  always_comb begin
    div_trial = {div_rem, div_num[NUMW-1]};
    div_ge    = div_trial >= {1'b0, div_den};
    div_rem_n = div_ge ? DW'(div_trial - {1'b0, div_den}) : DW'(div_trial);
  end

  // texture coordinate, taken modulo 2^(2F)
  always_comb begin
    tp_sh = ACC_W'((64'(side ? px : py)) << FRAC_BITS);
    pr_lo = ACC_W'(prod);
    acc_n = (side ? dx[grc_pkg::DIR_W-1] : dy[grc_pkg::DIR_W-1]) ? tp_sh - pr_lo
                                                                 : tp_sh + pr_lo;
  end

  always_comb begin
    half    = (grc_pkg::LH_W - 1)'(lh >> 1);
    hh      = grc_pkg::LH_W'(screen_height >> 1);
    start_w = (hh > grc_pkg::LH_W'(half)) ? hh - grc_pkg::LH_W'(half) : '0;
    end_w   = grc_pkg::LH_W'(half) + hh;
    if (end_w > grc_pkg::LH_W'(screen_height)) begin
      end_w = grc_pkg::LH_W'(screen_height);
    end
    mirror = (!side && !dx[grc_pkg::DIR_W-1] && (dx != '0)) || (side && dy[grc_pkg::DIR_W-1]);
    if (tex_width == '0) begin
      tex_f = '0;
    end else if (mirror) begin
      tex_f = tex_width - tex - grc_pkg::TW_W'(1);
    end else begin
      tex_f = tex;
    end
    hx_c = cx[CSW-1] ? '0 : ((cx >= MAP_S) ? CSW'(MAP_MAX) : CSW'(cx));
    hy_c = cy[CSW-1] ? '0 : ((cy >= MAP_S) ? CSW'(MAP_MAX) : CSW'(cy));
    if (side) begin
      face_w = dy[grc_pkg::DIR_W-1] ? grc_pkg::FACE_NORTH : grc_pkg::FACE_SOUTH;
    end else begin
      face_w = dx[grc_pkg::DIR_W-1] ? grc_pkg::FACE_WEST : grc_pkg::FACE_EAST;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      grc_pkg::ST_CLEAR: begin
        if (clr_addr == LAST_A) state_next = grc_pkg::ST_IDLE;
      end
      grc_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (func == grc_pkg::FUNC_WRITE) state_next = grc_pkg::ST_DONE;
          else if (out_x || out_y)         state_next = grc_pkg::ST_LH;
          else                             state_next = grc_pkg::ST_DELX;
        end
      end
      grc_pkg::ST_DELX: begin
        state_next = (dmx == '0) ? grc_pkg::ST_DELY : grc_pkg::ST_DIV;
      end
      grc_pkg::ST_DELY: begin
        state_next = (dmy == '0) ? grc_pkg::ST_SIDEX : grc_pkg::ST_DIV;
      end
      grc_pkg::ST_DIV: begin
        if (div_cnt == '0) state_next = grc_pkg::ST_DIVEND;
      end
      grc_pkg::ST_DIVEND: begin
        case (div_op)
          grc_pkg::DOP_DX:   state_next = grc_pkg::ST_DELY;
          grc_pkg::DOP_DY:   state_next = grc_pkg::ST_SIDEX;
          grc_pkg::DOP_PERP: state_next = grc_pkg::ST_LH;
          default:           state_next = grc_pkg::ST_TEX0;
        endcase
      end
      grc_pkg::ST_SIDEX:  state_next = grc_pkg::ST_SIDEY;
      grc_pkg::ST_SIDEY:  state_next = grc_pkg::ST_SIDEND;
      grc_pkg::ST_SIDEND: state_next = grc_pkg::ST_STEP;
      grc_pkg::ST_STEP: begin
        state_next = in_map_n ? grc_pkg::ST_CHECK : grc_pkg::ST_PERP;
      end
      grc_pkg::ST_CHECK: begin
        state_next = mem_q ? grc_pkg::ST_PERP : grc_pkg::ST_STEP;
      end
      grc_pkg::ST_PERP: begin
        state_next = (p_dmag == '0) ? grc_pkg::ST_LH : grc_pkg::ST_DIV;
      end
      grc_pkg::ST_LH: begin
        state_next = (wdist == '0) ? grc_pkg::ST_TEX0 : grc_pkg::ST_DIV;
      end
      grc_pkg::ST_TEX0: state_next = grc_pkg::ST_TEX1;
      grc_pkg::ST_TEX1: state_next = grc_pkg::ST_TEX2;
      grc_pkg::ST_TEX2: state_next = grc_pkg::ST_TEX3;
      grc_pkg::ST_TEX3: state_next = grc_pkg::ST_TEX4;
      grc_pkg::ST_TEX4: state_next = grc_pkg::ST_DONE;
      grc_pkg::ST_DONE: begin
        if (out_free) state_next = grc_pkg::ST_IDLE;
      end
      default: state_next = grc_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall  = (state != grc_pkg::ST_IDLE);
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = 1'b0;
    case (state)
      grc_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
      end
      grc_pkg::ST_IDLE: begin
        mem_we    = in_valid && (func == grc_pkg::FUNC_WRITE) && cell_ok;
        mem_waddr = wr_addr;
        mem_wdata = cell_wall;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      wmap[mem_waddr] <= mem_wdata;
    end
    mem_q <= wmap[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= grc_pkg::ST_CLEAR;
      clr_addr      <= '0;
      out_valid     <= 1'b0;
      screen_height <= grc_pkg::SCREEN_HEIGHT_RST;
      height_scale  <= grc_pkg::HEIGHT_SCALE_RST;
      tex_width     <= grc_pkg::TEX_WIDTH_RST;
    end else begin
      state <= state_next;
      if (state == grc_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (state == grc_pkg::ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          grc_pkg::CFG_SCREEN_HEIGHT: screen_height <= grc_pkg::H_W'(cfg_data);
          grc_pkg::CFG_HEIGHT_SCALE:  height_scale  <= cfg_data;
          grc_pkg::CFG_TEX_WIDTH:     tex_width     <= grc_pkg::TW_W'(cfg_data);
          default: ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      grc_pkg::ST_IDLE: begin
        if (in_acc) begin
          px       <= player_x;
          py       <= player_y;
          dx       <= dir_x;
          dy       <= dir_y;
          is_ray_w <= func;
          side     <= 1'b0;
          left     <= out_x || out_y;
          wdist    <= '0;
          cx       <= out_x ? MAP_MAX : CSW'(cx0_w);
          cy       <= out_y ? MAP_MAX : CSW'(cy0_w);
        end
      end
      grc_pkg::ST_DELX: begin
        if (dmx == '0) begin
          delta_x <= grc_pkg::SD_CAP;
        end else begin
          div_num <= NUMW'(1) << (2 * FRAC_BITS);
          div_den <= DW'(dmx);
          div_rem <= '0;
          div_q   <= '0;
          div_cnt <= CNT_W'(NUMW - 1);
          div_op  <= grc_pkg::DOP_DX;
        end
      end
      grc_pkg::ST_DELY: begin
        if (dmy == '0) begin
          delta_y <= grc_pkg::SD_CAP;
        end else begin
          div_num <= NUMW'(1) << (2 * FRAC_BITS);
          div_den <= DW'(dmy);
          div_rem <= '0;
          div_q   <= '0;
          div_cnt <= CNT_W'(NUMW - 1);
          div_op  <= grc_pkg::DOP_DY;
        end
      end
      grc_pkg::ST_DIV: begin
        div_rem <= div_rem_n;
        div_q   <= {div_q[NUMW-2:0], div_ge};
        div_num <= div_num << 1;
        div_cnt <= div_cnt - CNT_W'(1);
      end
      grc_pkg::ST_DIVEND: begin
        case (div_op)
          grc_pkg::DOP_DX: begin
            delta_x <= (64'(div_q) > 64'(grc_pkg::SD_CAP)) ? grc_pkg::SD_CAP
                                                           : grc_pkg::SD_W'(div_q);
          end
          grc_pkg::DOP_DY: begin
            delta_y <= (64'(div_q) > 64'(grc_pkg::SD_CAP)) ? grc_pkg::SD_CAP
                                                           : grc_pkg::SD_W'(div_q);
          end
          grc_pkg::DOP_PERP: begin
            wdist <= (64'(div_q) > 64'(grc_pkg::DIST_CAP)) ? grc_pkg::DIST_CAP
                                                           : grc_pkg::DIST_W'(div_q);
          end
          default: begin
            lh <= (64'(div_q) > 64'(grc_pkg::LH_CAP)) ? grc_pkg::LH_CAP
                                                      : grc_pkg::LH_W'(div_q);
          end
        endcase
      end
      grc_pkg::ST_SIDEX: begin
        prod <= mul_p;
      end
      grc_pkg::ST_SIDEY: begin
        side_x <= (prod_sh > MP'(grc_pkg::SD_CAP)) ? grc_pkg::SD_CAP : grc_pkg::SD_W'(prod_sh);
        prod   <= mul_p;
      end
      grc_pkg::ST_SIDEND: begin
        side_y <= (prod_sh > MP'(grc_pkg::SD_CAP)) ? grc_pkg::SD_CAP : grc_pkg::SD_W'(prod_sh);
      end
      grc_pkg::ST_STEP: begin
        cx <= cx_n;
        cy <= cy_n;
        if (take_x) begin
          side_x <= sum_x[grc_pkg::SD_W] ? grc_pkg::SD_CAP : sum_x[grc_pkg::SD_W-1:0];
          side   <= 1'b0;
        end else begin
          side_y <= sum_y[grc_pkg::SD_W] ? grc_pkg::SD_CAP : sum_y[grc_pkg::SD_W-1:0];
          side   <= 1'b1;
        end
        if (!in_map_n) begin
          left <= 1'b1;
        end
      end
      grc_pkg::ST_PERP: begin
        if (p_dmag == '0) begin
          wdist <= grc_pkg::DIST_CAP;
        end else begin
          div_num <= NUMW'(p_mag) << FRAC_BITS;
          div_den <= DW'(p_dmag);
          div_rem <= '0;
          div_q   <= '0;
          div_cnt <= CNT_W'(NUMW - 1);
          div_op  <= grc_pkg::DOP_PERP;
        end
      end
      grc_pkg::ST_LH: begin
        if (wdist == '0) begin
          lh <= grc_pkg::LH_CAP;
        end else begin
          div_num <= NUMW'(height_scale) << FRAC_BITS;
          div_den <= wdist;
          div_rem <= '0;
          div_q   <= '0;
          div_cnt <= CNT_W'(NUMW - 1);
          div_op  <= grc_pkg::DOP_LH;
        end
      end
      grc_pkg::ST_TEX0: begin
        prod <= mul_p;
      end
      grc_pkg::ST_TEX1: begin
        acc <= acc_n;
      end
      grc_pkg::ST_TEX2: begin
        prod <= mul_p;
      end
      grc_pkg::ST_TEX3: begin
        tex_lo <= grc_pkg::TW_W'(prod_sh);
        prod   <= mul_p;
      end
      grc_pkg::ST_TEX4: begin
        tex <= grc_pkg::TW_W'((prod + MP'(tex_lo)) >> FRAC_BITS);
      end
      grc_pkg::ST_DONE: begin
        if (out_free) begin
          is_ray <= is_ray_w;
          if (is_ray_w) begin
            wall_distance <= wdist;
            hit_side      <= side;
            face          <= face_w;
            hit_x         <= grc_pkg::CELL_W'(hx_c);
            hit_y         <= grc_pkg::CELL_W'(hy_c);
            left_map      <= left;
            draw_start    <= grc_pkg::H_W'(start_w);
            draw_end      <= grc_pkg::H_W'(end_w);
            tex_column    <= grc_pkg::TEX_W'(tex_f);
          end else begin
            wall_distance <= '0;
            hit_side      <= 1'b0;
            face          <= grc_pkg::FACE_EAST;
            hit_x         <= '0;
            hit_y         <= '0;
            left_map      <= 1'b0;
            draw_start    <= '0;
            draw_end      <= '0;
            tex_column    <= '0;
          end
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_busy_after_ray: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && func |=> in_stall)
    else $error("ray accepted but block not busy");

  a_div_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == grc_pkg::ST_DIV |-> div_den != '0)
    else $error("divider running with zero divisor");

  a_check_in_map: assert property (@(posedge clk) disable iff (rst)
    state == grc_pkg::ST_CHECK |-> !cx[CSW-1] && cx < MAP_S && !cy[CSW-1] && cy < MAP_S)
    else $error("map lookup outside the map");

  a_write_ack_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_ray |-> wall_distance == '0 && !left_map && draw_end == '0)
    else $error("write acknowledge carries ray data");
`endif

endmodule

@@ bench/tb.sv @@
module tb;

  localparam int FRAC = 16;
  localparam int MAP = 64;
  localparam int LAT = 600;
  localparam int WDOG_LIMIT = 20000;

  typedef struct packed {
    logic [grc_pkg::DIST_W-1:0] wall_distance;
    logic                       hit_side;
    logic [1:0]                 face;
    logic [grc_pkg::CELL_W-1:0] hit_x;
    logic [grc_pkg::CELL_W-1:0] hit_y;
    logic                       left_map;
    logic [grc_pkg::H_W-1:0]    draw_start;
    logic [grc_pkg::H_W-1:0]    draw_end;
    logic [grc_pkg::TEX_W-1:0]  tex_column;
    logic                       is_ray;
  } cast_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic func = grc_pkg::FUNC_WRITE;
  logic [grc_pkg::CELL_W-1:0] cell_x = '0;
  logic [grc_pkg::CELL_W-1:0] cell_y = '0;
  logic cell_wall = 1'b0;
  logic [grc_pkg::POS_W-1:0] player_x = '0;
  logic [grc_pkg::POS_W-1:0] player_y = '0;
  logic signed [grc_pkg::DIR_W-1:0] dir_x = '0;
  logic signed [grc_pkg::DIR_W-1:0] dir_y = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [grc_pkg::CFG_IDX_W-1:0] cfg_index = grc_pkg::CFG_SCREEN_HEIGHT;
  logic [grc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  cast_res_t got;

  grid_ray_caster i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .cell_x(cell_x), .cell_y(cell_y), .cell_wall(cell_wall),
    .player_x(player_x), .player_y(player_y), .dir_x(dir_x), .dir_y(dir_y),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .wall_distance(got.wall_distance), .hit_side(got.hit_side), .face(got.face),
    .hit_x(got.hit_x), .hit_y(got.hit_y), .left_map(got.left_map),
    .draw_start(got.draw_start), .draw_end(got.draw_end),
    .tex_column(got.tex_column), .is_ray(got.is_ray)
  );

  bit wall_model [MAP*MAP];
  longint unsigned scr_h, h_scale, tex_w;
  cast_res_t pending_res [$];
  int mismatches = 0;
  int src_idle = 0;
  int snk_idle = 0;
  int quiet_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned inv_delta(longint unsigned m);
    longint unsigned d;
    if (m == 0) return 64'hFFFF_FFFF;
    d = 64'h1_0000_0000 / m;
    return d > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : d;
  endfunction

  function automatic longint unsigned start_side(longint unsigned pos, longint c, bit neg,
                                                 longint unsigned delta);
    longint unsigned base, fr, s;
    base = longint'(c) << FRAC;
    fr = neg ? pos - base : base + (64'd1 << FRAC) - pos;
    s = (fr * delta) >> FRAC;
    return s > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : s;
  endfunction

  function automatic longint unsigned perp(longint c, longint s, longint unsigned pos,
                                           longint unsigned dmag);
    longint num;
    longint unsigned m, d;
    if (dmag == 0) return 64'hFF_FFFF;
    num = ((c + (s < 0 ? 1 : 0)) <<< FRAC) - longint'(pos);
    m = num < 0 ? -num : num;
    d = (m << FRAC) / dmag;
    return d > 64'hFF_FFFF ? 64'hFF_FFFF : d;
  endfunction

  function automatic cast_res_t trace_ray(logic [grc_pkg::POS_W-1:0] pxi,
                                          logic [grc_pkg::POS_W-1:0] pyi,
                                          logic signed [grc_pkg::DIR_W-1:0] dxi,
                                          logic signed [grc_pkg::DIR_W-1:0] dyi);
    cast_res_t r;
    longint dx, dy, cx, cy, sx, sy, acc;
    longint unsigned px, py, dmx, dmy, ddx, ddy, sdx, sdy, wd, lh, half, hh;
    longint unsigned start, stop, tpos, frc, tex;
    bit side, left;
    px = pxi; py = pyi; dx = dxi; dy = dyi;
    dmx = dx < 0 ? -dx : dx;
    dmy = dy < 0 ? -dy : dy;
    sx = dx < 0 ? -1 : 1;
    sy = dy < 0 ? -1 : 1;
    cx = px >> FRAC;
    cy = py >> FRAC;
    side = 0;
    left = 0;
    if (cx >= MAP || cy >= MAP) begin
      left = 1;
      wd = 0;
    end else begin
      ddx = inv_delta(dmx);
      ddy = inv_delta(dmy);
      sdx = start_side(px, cx, sx < 0, ddx);
      sdy = start_side(py, cy, sy < 0, ddy);
      forever begin
        if (sdx < sdy) begin
          sdx = sdx + ddx > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : sdx + ddx;
          cx += sx;
          side = 0;
        end else begin
          sdy = sdy + ddy > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : sdy + ddy;
          cy += sy;
          side = 1;
        end
        if (cx < 0 || cx >= MAP || cy < 0 || cy >= MAP) begin
          left = 1;
          break;
        end
        if (wall_model[cy*MAP + cx]) break;
      end
      wd = side ? perp(cy, sy, py, dmy) : perp(cx, sx, px, dmx);
    end
    if (wd == 0) lh = 64'd1 << 20;
    else begin
      lh = (h_scale << FRAC) / wd;
      if (lh > (64'd1 << 20)) lh = 64'd1 << 20;
    end
    half = lh / 2;
    hh = scr_h / 2;
    start = hh > half ? hh - half : 0;
    stop = half + hh;
    if (stop > scr_h) stop = scr_h;
    tpos = side ? px : py;
    acc = longint'(tpos << FRAC) + longint'(wd) * (side ? dx : dy);
    frc = acc & 64'hFFFF_FFFF;
    tex = 0;
    if (tex_w != 0) begin
      tex = (frc * tex_w) >> (2*FRAC);
      if ((!side && dx > 0) || (side && dy < 0)) tex = tex_w - tex - 1;
    end
    r.wall_distance = wd[grc_pkg::DIST_W-1:0];
    r.hit_side = side;
    if (!side) r.face = sx > 0 ? grc_pkg::FACE_EAST : grc_pkg::FACE_WEST;
    else r.face = sy > 0 ? grc_pkg::FACE_SOUTH : grc_pkg::FACE_NORTH;
    r.hit_x = grc_pkg::CELL_W'(cx < 0 ? 0 : (cx >= MAP ? MAP-1 : cx));
    r.hit_y = grc_pkg::CELL_W'(cy < 0 ? 0 : (cy >= MAP ? MAP-1 : cy));
    r.left_map = left;
    r.draw_start = start[grc_pkg::H_W-1:0];
    r.draw_end = stop[grc_pkg::H_W-1:0];
    r.tex_column = tex[grc_pkg::TEX_W-1:0];
    r.is_ray = 1'b1;
    return r;
  endfunction

  // drive one transaction; valid stays high so back-to-back items need no gap
  task automatic send_item(logic f, logic [grc_pkg::CELL_W-1:0] x,
                           logic [grc_pkg::CELL_W-1:0] y, logic w,
                           logic [grc_pkg::POS_W-1:0] px, logic [grc_pkg::POS_W-1:0] py,
                           logic signed [grc_pkg::DIR_W-1:0] dx,
                           logic signed [grc_pkg::DIR_W-1:0] dy);
    while ($urandom_range(99) < src_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    func <= f; cell_x <= x; cell_y <= y; cell_wall <= w;
    player_x <= px; player_y <= py; dir_x <= dx; dir_y <= dy;
    in_valid <= 1'b1;
    if (f == grc_pkg::FUNC_WRITE) begin
      wall_model[y*MAP + x] = w;
      pending_res.push_back('0);
    end else begin
      pending_res.push_back(trace_ray(px, py, dx, dy));
    end
    do @(posedge clk); while (in_stall);
  endtask

  task automatic put_cell(int x, int y, bit w);
    send_item(grc_pkg::FUNC_WRITE, grc_pkg::CELL_W'(x), grc_pkg::CELL_W'(y), w,
              grc_pkg::POS_W'($urandom), grc_pkg::POS_W'($urandom),
              grc_pkg::DIR_W'($urandom), grc_pkg::DIR_W'($urandom));
  endtask

  task automatic shoot(logic [grc_pkg::POS_W-1:0] px, logic [grc_pkg::POS_W-1:0] py,
                       logic signed [grc_pkg::DIR_W-1:0] dx,
                       logic signed [grc_pkg::DIR_W-1:0] dy);
    send_item(grc_pkg::FUNC_RAY, grc_pkg::CELL_W'($urandom), grc_pkg::CELL_W'($urandom),
              1'($urandom), px, py, dx, dy);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (LAT) @(posedge clk);
  endtask

  task automatic write_reg(logic [grc_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_index <= idx;
    cfg_data <= val[grc_pkg::CFG_DATA_W-1:0];
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      grc_pkg::CFG_SCREEN_HEIGHT: scr_h = val & 12'hFFF;
      grc_pkg::CFG_HEIGHT_SCALE:  h_scale = val & 16'hFFFF;
      grc_pkg::CFG_TEX_WIDTH:     tex_w = val & 11'h7FF;
      default: ;
    endcase
  endtask

  task automatic set_view(int unsigned h, int unsigned hs, int unsigned tw);
    drain();
    write_reg(grc_pkg::CFG_SCREEN_HEIGHT, h);
    write_reg(grc_pkg::CFG_HEIGHT_SCALE, hs);
    write_reg(grc_pkg::CFG_TEX_WIDTH, tw);
  endtask

  task automatic test_directed();
    put_cell(10, 5, 1);
    put_cell(5, 10, 1);
    put_cell(0, 0, 1);
    put_cell(63, 63, 1);
    put_cell(63, 63, 0);
    put_cell(12, 12, 1);
    shoot(22'h058000, 22'h058000, 18'sh10000, '0);      // east onto a wall
    shoot(22'h058000, 22'h058000, '0, 18'sh10000);      // south onto a wall
    shoot(22'h058000, 22'h058000, -18'sh10000, '0);     // west out of the map
    shoot(22'h058000, 22'h058000, '0, -18'sh10000);     // north out of the map
    shoot(22'h058000, 22'h058000, '0, '0);              // no direction at all
    shoot(22'h058000, 22'h058000, 18'sh0C000, 18'sh0C000);
    shoot(22'h010000, 22'h010000, -18'sh20000, -18'sh20000);
    shoot(22'h3FFFFF, 22'h3FFFFF, 18'sh1FFFF, 18'sh1FFFF);
    shoot(22'h3FFFFF, 22'h000000, -18'sh20000, 18'sh1FFFF);
    shoot(22'h000000, 22'h3FFFFF, 18'sh00001, -18'sh00001);
    shoot(22'h0A0000, 22'h058000, 18'sh10000, '0);      // standing on a wall edge
    shoot(22'h058000, 22'h058000, 18'sh10000, 18'sh00001);
    put_cell(12, 12, 0);
    put_cell(10, 5, 0);
  endtask

  task automatic test_random(int n, int si, int ki);
    int kind;
    logic signed [grc_pkg::DIR_W-1:0] dx, dy;
    src_idle = si;
    snk_idle = ki;
    repeat (n) begin
      if ($urandom_range(99) < 30) begin
        put_cell($urandom_range(MAP-1), $urandom_range(MAP-1), $urandom_range(99) < 35);
      end else begin
        kind = $urandom_range(9);
        dx = grc_pkg::DIR_W'($urandom);
        dy = grc_pkg::DIR_W'($urandom);
        if (kind == 0) dx = 0;
        else if (kind == 1) dy = 0;
        else if (kind == 2) begin dx = 0; dy = 0; end
        else if (kind < 6) begin
          dx = $signed(18'($urandom_range(0, 20'h3FFFF))) >>> $urandom_range(0, 8);
          dy = $signed(18'($urandom_range(0, 20'h3FFFF))) >>> $urandom_range(0, 8);
        end
        shoot(grc_pkg::POS_W'($urandom), grc_pkg::POS_W'($urandom), dx, dy);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_res.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else if (got !== pending_res[0]) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, actual %p", pending_res[0], got);
        void'(pending_res.pop_front());
      end else begin
        void'(pending_res.pop_front());
      end
    end
    out_stall <= ($urandom_range(99) < snk_idle);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    scr_h = 480;
    h_scale = 640;
    tex_w = 64;
    foreach (wall_model[i]) wall_model[i] = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(460, 0, 0);
    set_view(2048, 65535, 1024);
    test_directed();
    test_random(460, 71, 0);
    set_view(1, 1, 1);
    test_random(460, 0, 71);
    set_view(777, 12345, 0);
    test_random(200, 30, 30);
    set_view(1000, 40000, 2047);
    test_random(250, 30, 30);
    drain();
    if (mismatches == 0 && pending_res.size() == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end
endmodule
